>>> design/i2crt_pkg.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - shared package
// Item and result types, phase and stage codes, and the per-phase bus step.
// ----------------------------------------------------------------------------
package i2crt_pkg;

  localparam int WRITE_DEPTH_DEFAULT = 16;
  localparam logic [7:0] TPD_RESET = 8'd4;

  // item kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // bus phases
  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST_A   = 5'd1;
  localparam logic [4:0] PH_ST_B   = 5'd2;
  localparam logic [4:0] PH_ST_C   = 5'd3;
  localparam logic [4:0] PH_TX_SET = 5'd4;
  localparam logic [4:0] PH_TX_HI  = 5'd5;
  localparam logic [4:0] PH_TX_LO  = 5'd6;
  localparam logic [4:0] PH_AK_REL = 5'd7;
  localparam logic [4:0] PH_AK_HI  = 5'd8;
  localparam logic [4:0] PH_AK_SMP = 5'd9;
  localparam logic [4:0] PH_AK_END = 5'd10;
  localparam logic [4:0] PH_RX_BEG = 5'd11;
  localparam logic [4:0] PH_RX_HI  = 5'd12;
  localparam logic [4:0] PH_RX_LO  = 5'd13;
  localparam logic [4:0] PH_RA_A   = 5'd14;
  localparam logic [4:0] PH_RA_B   = 5'd15;
  localparam logic [4:0] PH_RA_C   = 5'd16;
  localparam logic [4:0] PH_SP_A   = 5'd17;
  localparam logic [4:0] PH_SP_B   = 5'd18;
  localparam logic [4:0] PH_SP_END = 5'd19;

  // byte stages of a transfer
  localparam logic [2:0] STG_DEV_W = 3'd0;
  localparam logic [2:0] STG_REG   = 3'd1;
  localparam logic [2:0] STG_DATA  = 3'd2;
  localparam logic [2:0] STG_DEV_R = 3'd3;
  localparam logic [2:0] STG_READ  = 3'd4;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] LAST_BIT      = 4'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_in;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic       is_read;
    logic [7:0] count;
    logic [7:0] write_byte;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       done_res;
    logic       error;
  } result_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [3:0] bit_index;
    logic [7:0] shift_byte;
    logic [7:0] bytes_left;
    logic [6:0] held_dev_addr;
    logic [7:0] held_reg_addr;
    logic       held_is_read;
    logic       scl;
    logic       sda;
    logic       drive;
    logic [2:0] stage;
    logic       got_nack;
    logic       aborted;
  } seq_t;

  localparam seq_t SEQ_RESET = '{
    phase: PH_IDLE, bit_index: 4'd0, shift_byte: 8'd0, bytes_left: 8'd0,
    held_dev_addr: 7'd0, held_reg_addr: 8'd0, held_is_read: 1'b0,
    scl: 1'b1, sda: 1'b1, drive: 1'b1, stage: STG_DEV_W,
    got_nack: 1'b0, aborted: 1'b0
  };

  typedef struct packed {
    seq_t       st;
    logic       hold;
    logic       term;
    logic       pop;
    logic       clear;
    logic       rvalid;
    logic [7:0] rbyte;
    logic       done;
    logic       err;
  } step_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic       rewind;
    logic [7:0] data;
  } queue_ctl_t;

  typedef struct packed {
    logic       avail;
    logic [7:0] head;
  } queue_stat_t;

  // One bus phase. hold: a delay follows; term: the transfer is over.
  function automatic step_t seq_phase(input seq_t s, input logic sda_in,
                                      input logic q_avail, input logic [7:0] q_head);
    step_t      r;
    logic [3:0] bi;
    r = '0;
    r.st = s;
    r.hold = 1'b1;
    bi = s.bit_index + 4'd1;
    case (s.phase)
      PH_ST_A: begin
        r.st.drive = 1'b1; r.st.sda = 1'b1; r.st.scl = 1'b1; r.st.phase = PH_ST_B;
      end
      PH_ST_B: begin
        r.st.sda = 1'b0; r.st.phase = PH_ST_C;
      end
      PH_ST_C: begin
        r.st.scl = 1'b0;
        r.st.shift_byte = {s.held_dev_addr, (s.stage == STG_DEV_R)};
        r.st.bit_index = 4'd0;
        r.st.phase = PH_TX_SET;
        r.hold = 1'b0;
      end
      PH_TX_SET: begin
        r.st.drive = 1'b1; r.st.sda = s.shift_byte[7]; r.st.phase = PH_TX_HI;
      end
      PH_TX_HI: begin
        r.st.scl = 1'b1; r.st.phase = PH_TX_LO;
      end
      PH_TX_LO: begin
        r.st.scl = 1'b0;
        if (s.bit_index == LAST_BIT) r.st.sda = 1'b1;
        r.st.shift_byte = {s.shift_byte[6:0], 1'b0};
        r.st.bit_index = bi;
        r.st.phase = (bi >= BITS_PER_BYTE) ? PH_AK_REL : PH_TX_SET;
      end
      PH_AK_REL: begin
        r.st.drive = 1'b0; r.st.sda = 1'b1; r.st.phase = PH_AK_HI;
      end
      PH_AK_HI: begin
        r.st.scl = 1'b1; r.st.phase = PH_AK_SMP;
      end
      PH_AK_SMP: begin
        r.st.got_nack = sda_in; r.st.scl = 1'b0; r.st.phase = PH_AK_END;
      end
      PH_AK_END: begin
        r.st.drive = 1'b1; r.st.sda = 1'b1; r.hold = 1'b0;
        r.st.phase = PH_SP_A;
        case (s.stage)
          STG_DEV_W: begin
            if (s.got_nack) begin
              r.st.aborted = 1'b1;
            end else begin
              r.st.shift_byte = s.held_reg_addr;
              r.st.bit_index = 4'd0;
              r.st.stage = STG_REG;
              r.st.phase = PH_TX_SET;
            end
          end
          STG_REG: begin
            if (s.held_is_read) begin
              r.st.stage = STG_DEV_R;
              r.st.phase = PH_ST_A;
            end else if (q_avail) begin
              r.pop = 1'b1;
              r.st.shift_byte = q_head;
              r.st.bit_index = 4'd0;
              r.st.stage = STG_DATA;
              r.st.phase = PH_TX_SET;
            end
          end
          STG_DATA: begin
            if (s.got_nack) begin
              r.st.aborted = 1'b1;
            end else if (q_avail) begin
              r.pop = 1'b1;
              r.st.shift_byte = q_head;
              r.st.bit_index = 4'd0;
              r.st.phase = PH_TX_SET;
            end
          end
          STG_DEV_R: begin
            if (s.bytes_left != 8'd0) begin
              r.st.stage = STG_READ;
              r.st.phase = PH_RX_BEG;
            end
          end
          default: begin
            r.st.phase = PH_SP_A;
          end
        endcase
      end
      PH_RX_BEG: begin
        r.st.shift_byte = 8'd0; r.st.bit_index = 4'd0;
        r.st.drive = 1'b0; r.st.scl = 1'b1; r.st.phase = PH_RX_LO;
      end
      PH_RX_HI: begin
        r.st.scl = 1'b1; r.st.phase = PH_RX_LO;
      end
      PH_RX_LO: begin
        r.st.shift_byte = {s.shift_byte[6:0], sda_in};
        r.st.scl = 1'b0;
        r.st.bit_index = bi;
        if (bi >= BITS_PER_BYTE) begin
          r.rvalid = 1'b1;
          r.rbyte = {s.shift_byte[6:0], sda_in};
          r.st.phase = PH_RA_A;
        end else begin
          r.st.phase = PH_RX_HI;
        end
      end
      PH_RA_A: begin
        if (s.bytes_left > 8'd1) begin
          r.st.scl = 1'b0; r.st.drive = 1'b1; r.st.sda = 1'b0;
        end else begin
          r.st.sda = 1'b1;
        end
        r.st.phase = PH_RA_B;
      end
      PH_RA_B: begin
        r.st.scl = 1'b1; r.st.phase = PH_RA_C;
      end
      PH_RA_C: begin
        r.st.scl = 1'b0;
        if (s.bytes_left > 8'd1) begin
          r.st.bytes_left = s.bytes_left - 8'd1;
          r.st.phase = PH_RX_BEG;
          r.hold = 1'b0;
        end else begin
          r.st.bytes_left = 8'd0;
          r.st.phase = PH_SP_A;
        end
      end
      PH_SP_A: begin
        r.st.drive = 1'b1; r.st.scl = 1'b0; r.st.sda = 1'b0; r.st.phase = PH_SP_B;
      end
      PH_SP_B: begin
        r.st.scl = 1'b1; r.st.sda = 1'b1; r.st.phase = PH_SP_END;
      end
      PH_SP_END: begin
        r.done = 1'b1;
        r.err = s.aborted;
        r.clear = ~s.held_is_read;
        r.st.phase = PH_IDLE;
        r.hold = 1'b0;
        r.term = 1'b1;
      end
      default: begin
        r.st.phase = PH_IDLE;
        r.hold = 1'b0;
        r.term = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

>>> design/i2crt_if.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface i2crt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       sda_in;
  logic [6:0] dev_addr;
  logic [7:0] reg_addr;
  logic       is_read;
  logic [7:0] count;
  logic [7:0] write_byte;

  modport source (output valid, kind, sda_in, dev_addr, reg_addr, is_read, count,
                  write_byte, input ready);
  modport sink (input valid, kind, sda_in, dev_addr, reg_addr, is_read, count,
                write_byte, output ready);
endinterface

interface i2crt_out_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       busy_res;
  logic       done_res;
  logic       error;

  modport source (output valid, scl, sda_out, sda_drive, read_valid, read_byte,
                  busy_res, done_res, error, input ready);
  modport sink (input valid, scl, sda_out, sda_drive, read_valid, read_byte,
                busy_res, done_res, error, output ready);
endinterface

>>> design/i2c_register_transfer_master.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - top level
// Register-addressed I2C reads and writes, stepped by timer tick items.
//
//   channel    dir   handshake        carries
//   in_item    in    valid/ready      kind, sda_in, addresses, count, write_byte
//   out_item   out   valid/ready      line levels, read byte, busy/done/error
//   apb        in    psel/penable     ticks_per_delay at byte address 0
//
// One item per clock while out_item is not stalled; each item is captured in
// an input register, applied to the sequencer state and its result lands in
// an output register. A stalled output register holds its result; the input
// register then takes at most one more item. Reset clears the bus state and
// the queue counts and sets ticks_per_delay to 4.
// ----------------------------------------------------------------------------
module i2c_register_transfer_master #(
  parameter int WRITE_DEPTH = i2crt_pkg::WRITE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  i2crt_in_if.sink    in_item,
  i2crt_out_if.source out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2crt_pkg::*;

  logic        in_valid;
  item_t       in_reg;
  logic        out_valid;
  result_t     out_reg;
  logic        advance;
  logic        step_en;
  result_t     res;
  queue_ctl_t  qctl;
  queue_stat_t qstat;
  logic [7:0]  ticks_per_delay;

  assign advance       = !out_valid || out_item.ready;
  assign step_en       = in_valid && advance;
  assign in_item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_item.ready) begin
      in_valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.ready && in_item.valid) begin
      in_reg.kind       <= in_item.kind;
      in_reg.sda_in     <= in_item.sda_in;
      in_reg.dev_addr   <= in_item.dev_addr;
      in_reg.reg_addr   <= in_item.reg_addr;
      in_reg.is_read    <= in_item.is_read;
      in_reg.count      <= in_item.count;
      in_reg.write_byte <= in_item.write_byte;
    end
  end

  i2crt_apb u_apb (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .ticks_per_delay (ticks_per_delay)
  );

  i2crt_queue #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  i2crt_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .en              (step_en),
    .item            (in_reg),
    .ticks_per_delay (ticks_per_delay),
    .qstat           (qstat),
    .qctl            (qctl),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_reg <= res;
    end
  end

  assign out_item.valid      = out_valid;
  assign out_item.scl        = out_reg.scl;
  assign out_item.sda_out    = out_reg.sda_out;
  assign out_item.sda_drive  = out_reg.sda_drive;
  assign out_item.read_valid = out_reg.read_valid;
  assign out_item.read_byte  = out_reg.read_byte;
  assign out_item.busy_res   = out_reg.busy_res;
  assign out_item.done_res   = out_reg.done_res;
  assign out_item.error      = out_reg.error;

endmodule

>>> design/i2crt_apb.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - configuration registers
// APB write/read of the bus delay length.
// ----------------------------------------------------------------------------
module i2crt_apb (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  ticks_per_delay
);
  import i2crt_pkg::*;

  logic wr_en;

  // only register 0 exists; the upper address bit selects beyond it
  assign wr_en  = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, ticks_per_delay};

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_delay <= TPD_RESET;
    end else if (wr_en) begin
      ticks_per_delay <= pwdata[7:0];
    end
  end

endmodule

>>> design/i2crt_queue.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - write byte queue
// Byte memory with fill count, read position and a registered head byte.
// ----------------------------------------------------------------------------
module i2crt_queue #(
  parameter int WRITE_DEPTH = i2crt_pkg::WRITE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  i2crt_pkg::queue_ctl_t    ctl,
  output i2crt_pkg::queue_stat_t   stat
);
  import i2crt_pkg::*;

  localparam int FW = $clog2(WRITE_DEPTH + 1);
  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;

  logic [7:0]    mem [WRITE_DEPTH];
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [FW-1:0] read_pos;
  logic [FW-1:0] read_pos_next;
  logic [7:0]    head;
  logic          push_ok;

  assign push_ok = ctl.push && (fill < FW'(WRITE_DEPTH));

  always_comb begin
    fill_next = fill;
    if (ctl.clear) begin
      fill_next = '0;
    end else if (push_ok) begin
      fill_next = fill + 1'b1;
    end
  end

  always_comb begin
    read_pos_next = read_pos;
    if (ctl.clear || ctl.rewind) begin
      read_pos_next = '0;
    end else if (ctl.pop) begin
      read_pos_next = read_pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      read_pos <= '0;
    end else begin
      fill     <= fill_next;
      read_pos <= read_pos_next;
    end
  end

  // head follows the next read position every cycle
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[fill[AW-1:0]] <= ctl.data;
    end
    head <= mem[read_pos_next[AW-1:0]];
  end

  assign stat.avail = (read_pos < fill) && (read_pos < FW'(WRITE_DEPTH));
  assign stat.head  = head;

endmodule

>>> design/i2crt_seq.sv
// ----------------------------------------------------------------------------
// I2C register transfer master - bus sequencer
// Holds the bus state and delay counter and applies one item per cycle while en is high.
// ----------------------------------------------------------------------------
module i2crt_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  i2crt_pkg::item_t        item,
  input  logic [7:0]              ticks_per_delay,
  input  i2crt_pkg::queue_stat_t  qstat,
  output i2crt_pkg::queue_ctl_t   qctl,
  output i2crt_pkg::result_t      res
);
  import i2crt_pkg::*;

  seq_t       state;
  seq_t       state_next;
  logic [7:0] delay_count;
  logic [7:0] delay_count_next;
  logic [7:0] delay_load;
  logic       busy;
  step_t      p1;
  step_t      p2;
  step_t      fin;

  assign busy       = state.phase != PH_IDLE;
  assign delay_load = (ticks_per_delay == 8'd0) ? 8'd1 : ticks_per_delay;

  // a phase that does not hold chains into exactly one more phase
  always_comb begin
    p1 = seq_phase(state, item.sda_in, qstat.avail, qstat.head);
    p2 = seq_phase(p1.st, item.sda_in, qstat.avail, qstat.head);
    fin = (p1.hold || p1.term) ? p1 : p2;
  end

  always_comb begin
    state_next       = state;
    delay_count_next = delay_count;
    qctl             = '0;
    qctl.data        = item.write_byte;
    res              = '0;
    case (item.kind)
      KIND_TICK: begin
        if (busy) begin
          if (delay_count > 8'd1) begin
            delay_count_next = delay_count - 8'd1;
          end else begin
            state_next       = fin.st;
            delay_count_next = fin.hold ? delay_load : 8'd0;
            qctl.pop         = p1.pop;
            qctl.clear       = p1.clear | fin.clear;
            res.read_valid   = p1.rvalid | fin.rvalid;
            res.read_byte    = p1.rbyte | fin.rbyte;
            res.done_res     = p1.done | fin.done;
            res.error        = p1.err | fin.err;
          end
        end
      end
      KIND_PUSH: begin
        qctl.push = ~busy;
      end
      KIND_START: begin
        if (!busy) begin
          state_next.held_dev_addr = item.dev_addr;
          state_next.held_reg_addr = item.reg_addr;
          state_next.held_is_read  = item.is_read;
          state_next.bytes_left    = item.count;
          state_next.stage         = STG_DEV_W;
          state_next.got_nack      = 1'b0;
          state_next.aborted       = 1'b0;
          state_next.bit_index     = 4'd0;
          state_next.shift_byte    = 8'd0;
          state_next.phase         = PH_ST_A;
          delay_count_next         = 8'd0;
          qctl.rewind              = 1'b1;
        end
      end
      default: begin
        state_next = state;
      end
    endcase
    if (!en) begin
      qctl.push   = 1'b0;
      qctl.pop    = 1'b0;
      qctl.clear  = 1'b0;
      qctl.rewind = 1'b0;
    end
    res.scl       = state_next.scl;
    res.sda_out   = state_next.sda;
    res.sda_drive = state_next.drive;
    res.busy_res  = state_next.phase != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SEQ_RESET;
      delay_count <= 8'd0;
    end else if (en) begin
      state       <= state_next;
      delay_count <= delay_count_next;
    end
  end

endmodule
